FILE: hdl/paged_block_allocator_macros.svh
// Assertion macros shared by the allocator modules.
`ifndef PAGED_BLOCK_ALLOCATOR_MACROS_SVH
`define PAGED_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/pba_pkg.sv
// Package with constants, codes and shared types of the paged block allocator.
package pba_pkg;
  localparam int NUM_BLOCKS  = 256;
  localparam int BLK_W       = $clog2(NUM_BLOCKS);
  localparam int CNT_W       = $clog2(NUM_BLOCKS + 1);
  localparam int PAGE_TOKENS = 16;
  localparam int PAGE_SHIFT  = $clog2(PAGE_TOKENS);
  localparam int MAX_SLOTS   = 8;
  localparam int SLOT_W      = $clog2(MAX_SLOTS);
  localparam int MAX_PAGES   = 16;
  localparam int PAGE_W      = $clog2(MAX_PAGES);
  localparam int HELD_W      = PAGE_W + 1;
  localparam int LIVE_W      = SLOT_W + 1;
  localparam int TOK_W       = 9;
  localparam int NEED_W      = 6;
  localparam int INIT_W      = 5;
  localparam int PT_AW       = SLOT_W + PAGE_W;
  localparam int ADDR_W      = 3;

  localparam logic [1:0] CMD_FINISH = 2'd0;
  localparam logic [1:0] CMD_GROW   = 2'd1;
  localparam logic [1:0] CMD_ADMIT  = 2'd2;

  localparam logic [ADDR_W-1:0] ADDR_INIT_BLOCKS = 3'd0;

  typedef enum logic [2:0] {
    K_MAPPED    = 3'd0,
    K_RELEASED  = 3'd1,
    K_PREEMPTED = 3'd2,
    K_REFUSED   = 3'd3,
    K_NOTHING   = 3'd4,
    K_ERROR     = 3'd5
  } pba_kind_t;

  typedef struct packed {
    logic             take;
    logic             give;
    logic [BLK_W-1:0] give_block;
  } pba_fl_op_t;

  typedef struct packed {
    logic             ready;
    logic [CNT_W-1:0] count;
  } pba_fl_stat_t;
endpackage

FILE: hdl/pba_page_table.sv
// Page table memory: one block number per slot and page, registered read.
module pba_page_table (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [pba_pkg::PT_AW-1:0] waddr,
  input  logic [pba_pkg::BLK_W-1:0] wdata,
  input  logic                  rd_en,
  input  logic [pba_pkg::PT_AW-1:0] raddr,
  output logic [pba_pkg::BLK_W-1:0] rdata
);
  import pba_pkg::*;

  logic [BLK_W-1:0] mem [MAX_SLOTS*MAX_PAGES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: hdl/pba_free_list.sv
// Free block FIFO: memory, head pointer, fill count and the clearing pass after reset.
`include "paged_block_allocator_macros.svh"
module pba_free_list (
  input  logic                  clk,
  input  logic                  rst,
  input  pba_pkg::pba_fl_op_t   op,
  output pba_pkg::pba_fl_stat_t stat,
  output logic [pba_pkg::BLK_W-1:0] rdata
);
  import pba_pkg::*;

  logic [BLK_W-1:0] mem [NUM_BLOCKS];
  logic [BLK_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [BLK_W-1:0] clr_idx;
  logic             clearing;
  logic [BLK_W-1:0] tail;
  logic             wr_en;
  logic [BLK_W-1:0] waddr;
  logic [BLK_W-1:0] wdata;

  assign tail  = head + count[BLK_W-1:0];
  assign wr_en = clearing || op.give;
  assign waddr = clearing ? clr_idx : tail;
  assign wdata = clearing ? clr_idx : op.give_block;
  assign stat.ready = !clearing;
  assign stat.count = count;

  // The reset image holds block i at entry i; one entry is written per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= CNT_W'(NUM_BLOCKS);
      clr_idx  <= '0;
      clearing <= 1'b1;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + BLK_W'(1);
        if (clr_idx == BLK_W'(NUM_BLOCKS - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (op.take) begin
        head  <= head + BLK_W'(1);
        count <= count - CNT_W'(1);
      end else if (op.give && count < CNT_W'(NUM_BLOCKS)) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (op.take) begin
      rdata <= mem[head];
    end
  end

  `PBA_ASSERT_IMP(a_take_nonempty, op.take, count != '0, "take from empty free list")
  `PBA_ASSERT_IMP(a_give_room, op.give, count < CNT_W'(NUM_BLOCKS), "give to full free list")
  `PBA_ASSERT_IMP(a_no_op_clearing, clearing, !op.take && !op.give, "access during clear")
endmodule

FILE: hdl/paged_block_allocator.sv
// Top level of the paged block allocator: command sequencer, slot state and result register.
//
//  channel   handshake                        payload
//  request   req_valid / req_ready            cmd, slot, token_count
//  result    res_valid / res_ready            kind, out_slot, page, block, last
//  config    psel, penable, pwrite, pready    paddr, pwdata, prdata (init_blocks at 0)
//
// One request is processed at a time. An admit issues one free list read and then maps one
// block per cycle while the result is not stalled; a finish walks the slot's page table one
// entry per cycle and then emits its result, and each preemption inside a grow walks the
// victim's page table the same way. The free list and page table memories each have one
// registered read. After reset a clearing pass fills the free list memory; no request is
// taken until it ends. A stalled result holds the sequencer until it is taken.
`include "paged_block_allocator_macros.svh"
module paged_block_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pba_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [1:0]                     cmd,
  input  logic [pba_pkg::SLOT_W-1:0]     slot,
  input  logic [pba_pkg::TOK_W-1:0]      token_count,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [2:0]                     kind,
  output logic [pba_pkg::SLOT_W-1:0]     out_slot,
  output logic [pba_pkg::PAGE_W-1:0]     page,
  output logic [7:0]                     block,
  output logic                           last
);
  import pba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_REL, S_GROW, S_TAKE_RD, S_TAKE_WR, S_EMIT
  } state_t;

  state_t state;

  // Configuration.
  logic [INIT_W-1:0] init_blocks;

  // Per-slot state and admission order.
  logic [HELD_W-1:0] held    [MAX_SLOTS];
  logic [HELD_W-1:0] init_pg [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] live;
  logic [SLOT_W-1:0] order [MAX_SLOTS];
  logic [LIVE_W-1:0] live_count;

  // Sequencer registers.
  logic [SLOT_W-1:0] cur_slot;
  logic [SLOT_W-1:0] rel_slot;
  logic              rel_pre;
  logic              is_admit;
  logic [HELD_W-1:0] pg;
  logic [HELD_W-1:0] left;
  logic [HELD_W-1:0] need_r;
  logic [HELD_W-1:0] rel_j;
  logic              pend;
  pba_kind_t         em_kind;
  logic [SLOT_W-1:0] em_slot;
  logic              em_last;
  state_t            em_next;
  pba_kind_t         res_kind;

  // Memory interfaces.
  pba_fl_op_t        fl_op;
  pba_fl_stat_t      fl_stat;
  logic [BLK_W-1:0]  fl_rdata;
  logic              pt_wr;
  logic              pt_rd;
  logic [PT_AW-1:0]  pt_waddr;
  logic [PT_AW-1:0]  pt_raddr;
  logic [BLK_W-1:0]  pt_rdata;

  // Combinational helpers.
  logic              can_emit;
  logic              req_acc;
  logic [SLOT_W-1:0] sel_slot;
  logic [HELD_W-1:0] sel_held;
  logic [HELD_W-1:0] sel_init;
  logic              sel_live;
  logic [HELD_W-1:0] grown;
  logic [HELD_W-1:0] rel_pg;
  logic              rel_done;
  logic [NEED_W-1:0] need_tok;
  logic [NEED_W-1:0] need;
  logic [TOK_W-1:0]  grow_bound;
  logic [SLOT_W-1:0] victim;
  logic [SLOT_W-1:0] order_rm [MAX_SLOTS];
  logic              rm_found;

  pba_free_list u_free_list (
    .clk   (clk),
    .rst   (rst),
    .op    (fl_op),
    .stat  (fl_stat),
    .rdata (fl_rdata)
  );

  pba_page_table u_page_table (
    .clk   (clk),
    .wr_en (pt_wr),
    .waddr (pt_waddr),
    .wdata (fl_rdata),
    .rd_en (pt_rd),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  // Configuration port: one register, written in the access phase.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_INIT_BLOCKS) ? 32'(init_blocks) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_blocks <= INIT_W'(1);
    end else if (psel && penable && pwrite && paddr == ADDR_INIT_BLOCKS) begin
      init_blocks <= pwdata[INIT_W-1:0];
    end
  end

  assign can_emit  = !res_valid || res_ready;
  assign req_ready = (state == S_IDLE) && fl_stat.ready;
  assign req_acc   = req_valid && req_ready;
  assign kind      = res_kind;

  // The slot state has one read port; the sequencer state picks whose entry it shows.
  always_comb begin
    case (state)
      S_IDLE:  sel_slot = slot;
      S_REL:   sel_slot = rel_slot;
      default: sel_slot = cur_slot;
    endcase
  end
  assign sel_held = held[sel_slot];
  assign sel_init = init_pg[sel_slot];
  assign sel_live = live[sel_slot];

  // Admit size: one page per PAGE_TOKENS tokens plus the next token, at least init_blocks.
  assign need_tok   = NEED_W'((10'(token_count) + 10'(PAGE_TOKENS)) >> PAGE_SHIFT);
  assign need       = (NEED_W'(init_blocks) > need_tok) ? NEED_W'(init_blocks) : need_tok;
  assign grow_bound = TOK_W'(sel_held) << PAGE_SHIFT;

  // A release returns the grown pages newest first, then the initial pages in order.
  assign grown    = sel_held - sel_init;
  assign rel_pg   = (rel_j < grown) ? (sel_held - HELD_W'(1) - rel_j) : (rel_j - grown);
  assign rel_done = (state == S_REL) && (rel_j == sel_held) && !pend;
  assign victim   = order[live_count[SLOT_W-1:0] - SLOT_W'(1)];

  assign pt_rd    = (state == S_REL) && (rel_j < sel_held);
  assign pt_raddr = {rel_slot, rel_pg[PAGE_W-1:0]};
  assign pt_wr    = (state == S_TAKE_WR) && can_emit;
  assign pt_waddr = {cur_slot, pg[PAGE_W-1:0]};

  always_comb begin
    fl_op.take = (state == S_TAKE_RD)
              || ((state == S_TAKE_WR) && can_emit && left != HELD_W'(1))
              || ((state == S_GROW) && fl_stat.count != '0);
    fl_op.give       = (state == S_REL) && pend;
    fl_op.give_block = pt_rdata;
  end

  // Admission order with the released slot taken out and the rest closed up.
  always_comb begin
    rm_found = 1'b0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (LIVE_W'(i) < live_count && order[i] == rel_slot) begin
        rm_found = 1'b1;
      end
      if (rm_found && i < MAX_SLOTS - 1) begin
        order_rm[i] = order[i + 1];
      end else begin
        order_rm[i] = order[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live       <= '0;
      live_count <= '0;
      res_valid  <= 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        held[i]    <= '0;
        init_pg[i] <= '0;
      end
    end else begin
      if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_acc) begin
            em_kind <= K_ERROR;
            em_slot <= slot;
            em_last <= 1'b1;
            em_next <= S_IDLE;
            state   <= S_EMIT;
            if ({1'b0, slot} >= LIVE_W'(MAX_SLOTS)) begin
              em_kind <= K_ERROR;
            end else begin
              case (cmd)
                CMD_FINISH: begin
                  if (sel_live) begin
                    rel_slot <= slot;
                    rel_pre  <= 1'b0;
                    rel_j    <= '0;
                    pend     <= 1'b0;
                    state    <= S_REL;
                  end else begin
                    em_kind <= K_NOTHING;
                  end
                end
                CMD_GROW: begin
                  if (!sel_live) begin
                    em_kind <= K_ERROR;
                  end else if (token_count != grow_bound) begin
                    em_kind <= K_NOTHING;
                  end else if (sel_held >= HELD_W'(MAX_PAGES)) begin
                    em_kind <= K_ERROR;
                  end else begin
                    cur_slot <= slot;
                    is_admit <= 1'b0;
                    state    <= S_GROW;
                  end
                end
                CMD_ADMIT: begin
                  if (sel_live) begin
                    em_kind <= K_REFUSED;
                  end else if (need > NEED_W'(MAX_PAGES)) begin
                    em_kind <= K_ERROR;
                  end else if (fl_stat.count < CNT_W'(need)) begin
                    em_kind <= K_REFUSED;
                  end else begin
                    cur_slot <= slot;
                    is_admit <= 1'b1;
                    pg       <= '0;
                    left     <= HELD_W'(need);
                    need_r   <= HELD_W'(need);
                    state    <= S_TAKE_RD;
                  end
                end
                default: begin
                  em_kind <= K_ERROR;
                end
              endcase
            end
          end
        end
        S_REL: begin
          if (pt_rd) begin
            rel_j <= rel_j + HELD_W'(1);
            pend  <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (rel_done) begin
            held[rel_slot]    <= '0;
            init_pg[rel_slot] <= '0;
            live[rel_slot]    <= 1'b0;
            if (rm_found) begin
              for (int i = 0; i < MAX_SLOTS; i++) begin
                order[i] <= order_rm[i];
              end
              live_count <= live_count - LIVE_W'(1);
            end
            em_slot <= rel_slot;
            if (rel_pre) begin
              em_kind <= K_PREEMPTED;
              em_last <= (rel_slot == cur_slot);
              em_next <= (rel_slot == cur_slot) ? S_IDLE : S_GROW;
            end else begin
              em_kind <= K_RELEASED;
              em_last <= 1'b1;
              em_next <= S_IDLE;
            end
            state <= S_EMIT;
          end
        end
        S_GROW: begin
          if (fl_stat.count == '0 && live_count != '0) begin
            rel_slot <= victim;
            rel_pre  <= 1'b1;
            rel_j    <= '0;
            pend     <= 1'b0;
            state    <= S_REL;
          end else if (fl_stat.count == '0) begin
            em_kind <= K_ERROR;
            em_slot <= cur_slot;
            em_last <= 1'b1;
            em_next <= S_IDLE;
            state   <= S_EMIT;
          end else begin
            pg    <= sel_held;
            left  <= HELD_W'(1);
            state <= S_TAKE_WR;
          end
        end
        S_TAKE_RD: begin
          state <= S_TAKE_WR;
        end
        S_TAKE_WR: begin
          if (can_emit) begin
            res_valid <= 1'b1;
            res_kind  <= K_MAPPED;
            out_slot  <= cur_slot;
            page      <= pg[PAGE_W-1:0];
            block     <= fl_rdata;
            last      <= (left == HELD_W'(1));
            pg        <= pg + HELD_W'(1);
            left      <= left - HELD_W'(1);
            if (left == HELD_W'(1)) begin
              state <= S_IDLE;
              if (is_admit) begin
                held[cur_slot]    <= need_r;
                init_pg[cur_slot] <= need_r;
                live[cur_slot]    <= 1'b1;
                if (live_count < LIVE_W'(MAX_SLOTS)) begin
                  order[live_count[SLOT_W-1:0]] <= cur_slot;
                  live_count <= live_count + LIVE_W'(1);
                end
              end else begin
                held[cur_slot] <= pg + HELD_W'(1);
              end
            end
          end
        end
        S_EMIT: begin
          if (can_emit) begin
            res_valid <= 1'b1;
            res_kind  <= em_kind;
            out_slot  <= em_slot;
            page      <= '0;
            block     <= '0;
            last      <= em_last;
            state     <= em_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PBA_ASSERT_IMP(a_live_count, 1'b1, $countones(live) == 32'(live_count), "live count mismatch")
  `PBA_ASSERT_IMP(a_take_left, state == S_TAKE_WR, left != '0, "mapping with nothing left")
  `PBA_ASSERT_NXT(a_rel_clears, rel_done, !live[rel_slot], "released slot still live")
endmodule
